>>> rtl/rxs_pkg.sv
// shared types, constants and control word layout for the record exchange sorter
`default_nettype none
package rxs_pkg;

    // capacity and field widths
    localparam int MAX_RECORDS = 64;
    localparam int ADDR_W      = $clog2(MAX_RECORDS);
    localparam int CNT_W       = $clog2(MAX_RECORDS + 1);
    localparam int ID_W        = 16;
    localparam int AGE_W       = 8;
    localparam int KEY_W       = 16;
    localparam int POS_W       = 6;
    localparam int STEP_W      = 3;

    typedef logic [STEP_W-1:0] step_t;

    // microprogram step addresses
    localparam step_t ST_LOAD  = 3'd0;
    localparam step_t ST_ROW   = 3'd1;
    localparam step_t ST_LDCUR = 3'd2;
    localparam step_t ST_CMP   = 3'd3;
    localparam step_t ST_WAIT  = 3'd4;
    localparam step_t ST_EMIT  = 3'd5;
    localparam step_t ST_DONE  = 3'd6;

    // memory read address source
    typedef enum logic [1:0] {
        RD_I,
        RD_J,
        RD_J1
    } rd_sel_t;

    // jump conditions
    typedef enum logic [2:0] {
        C_ALWAYS,
        C_LAST_ACC,
        C_J_END,
        C_J1_END,
        C_OUT_FREE,
        C_LAST_ROW
    } cond_t;

    // one control word of the microprogram
    typedef struct packed {
        logic    in_rdy;
        rd_sel_t rd_sel;
        logic    j_init;
        logic    ld_cur;
        logic    cmp_step;
        logic    emit;
        logic    clr_set;
        cond_t   cond;
        step_t   t_addr;
        step_t   f_addr;
    } ctrl_t;

    // datapath status seen by the sequencer
    typedef struct packed {
        logic last_acc;
        logic j_end;
        logic j1_end;
        logic out_free;
        logic last_row;
    } stat_t;

    // one stored record
    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [AGE_W-1:0] age;
        logic [KEY_W-1:0] key;
        logic [POS_W-1:0] pos;
    } rec_t;

endpackage
`default_nettype wire

>>> rtl/record_exchange_sort_desc.sv
// top level: record store, exchange sort datapath and result register
//
// Records are loaded one per cycle while s_ready is high; the transfer with
// s_last closes the set. The block then sorts the set in descending score
// order by the plain exchange procedure and delivers each record as soon as
// its position is settled. The sort does one compare per cycle against the
// single read port of the record memory, and delivery can be held back by
// m_ready. s_ready stays low while the set is sorted and delivered. Up to
// 64 records are kept; further records of a set are dropped and m_overflow
// is raised on every result of that set.
`default_nettype none
module record_exchange_sort_desc
    import rxs_pkg::*;
(
    input  wire              aclk,
    input  wire              aresetn,
    input  wire              s_valid,
    output logic             s_ready,
    input  wire [ID_W-1:0]   s_rec_id,
    input  wire [AGE_W-1:0]  s_age,
    input  wire [KEY_W-1:0]  s_score,
    input  wire              s_last,
    output logic             m_valid,
    input  wire              m_ready,
    output logic [ID_W-1:0]  m_out_id,
    output logic [AGE_W-1:0] m_out_age,
    output logic [KEY_W-1:0] m_out_score,
    output logic [POS_W-1:0] m_load_pos,
    output logic             m_final_res,
    output logic             m_overflow
);

    ctrl_t ctrl;
    stat_t stat;

    rec_t mem [MAX_RECORDS];
    rec_t rd_data_reg;
    rec_t cur_reg;
    rec_t cur_next;
    rec_t wr_data;
    rec_t out_reg;
    rec_t out_next;

    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] wr_addr;
    logic              wr_en;

    logic [CNT_W-1:0]  fill_count_reg;
    logic [CNT_W-1:0]  fill_count_next;
    logic              dropped_reg;
    logic              dropped_next;
    logic [ADDR_W-1:0] i_reg;
    logic [ADDR_W-1:0] i_next;
    logic [CNT_W-1:0]  j_reg;
    logic [CNT_W-1:0]  j_next;
    logic [CNT_W-1:0]  i_plus1;
    logic [CNT_W-1:0]  j_plus1;

    logic m_valid_reg;
    logic m_valid_next;
    logic final_reg;
    logic final_next;
    logic ovf_reg;
    logic ovf_next;

    logic in_xfer;
    logic has_room;
    logic swap;

    rxs_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .stat    (stat),
        .ctrl    (ctrl)
    );

    assign s_ready  = ctrl.in_rdy;
    assign in_xfer  = s_valid && ctrl.in_rdy;
    assign has_room = (fill_count_reg < CNT_W'(MAX_RECORDS));
    assign i_plus1  = CNT_W'(i_reg) + CNT_W'(1);
    assign j_plus1  = j_reg + CNT_W'(1);
    assign swap     = ctrl.cmp_step && (cur_reg.key < rd_data_reg.key);

    // status to the sequencer
    always_comb begin
        stat.last_acc = in_xfer && s_last;
        stat.j_end    = (j_reg == fill_count_reg);
        stat.j1_end   = (j_plus1 == fill_count_reg);
        stat.out_free = !m_valid_reg || m_ready;
        stat.last_row = (i_plus1 == fill_count_reg);
    end

    // read address select
    always_comb begin
        case (ctrl.rd_sel)
            RD_I:    rd_addr = i_reg;
            RD_J:    rd_addr = j_reg[ADDR_W-1:0];
            RD_J1:   rd_addr = j_plus1[ADDR_W-1:0];
            default: rd_addr = i_reg;
        endcase
    end

    // write port: loading a record or moving the held record down on a swap
    always_comb begin
        wr_en = (in_xfer && has_room) || swap;
        if (ctrl.cmp_step) begin
            wr_addr = j_reg[ADDR_W-1:0];
            wr_data = cur_reg;
        end else begin
            wr_addr     = fill_count_reg[ADDR_W-1:0];
            wr_data.id  = s_rec_id;
            wr_data.age = s_age;
            wr_data.key = s_score;
            wr_data.pos = POS_W'(fill_count_reg);
        end
    end

    // record memory with registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // held record of the current row
    always_comb begin
        cur_next = cur_reg;
        if (ctrl.ld_cur || swap) begin
            cur_next = rd_data_reg;
        end
    end

    // fill count, drop flag and loop indices
    always_comb begin
        fill_count_next = fill_count_reg;
        dropped_next    = dropped_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        if (in_xfer) begin
            if (has_room) begin
                fill_count_next = fill_count_reg + CNT_W'(1);
            end else begin
                dropped_next = 1'b1;
            end
        end
        if (ctrl.j_init) begin
            j_next = i_plus1;
        end
        if (ctrl.cmp_step) begin
            j_next = j_plus1;
        end
        if (ctrl.emit) begin
            i_next = i_reg + ADDR_W'(1);
        end
        if (ctrl.clr_set) begin
            fill_count_next = '0;
            dropped_next    = 1'b0;
            i_next          = '0;
        end
    end

    // result register
    always_comb begin
        m_valid_next = m_valid_reg;
        out_next     = out_reg;
        final_next   = final_reg;
        ovf_next     = ovf_reg;
        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        if (ctrl.emit) begin
            m_valid_next = 1'b1;
            out_next     = cur_reg;
            final_next   = stat.last_row;
            ovf_next     = dropped_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_count_reg <= '0;
            dropped_reg    <= 1'b0;
            i_reg          <= '0;
            j_reg          <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            fill_count_reg <= fill_count_next;
            dropped_reg    <= dropped_next;
            i_reg          <= i_next;
            j_reg          <= j_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        cur_reg   <= cur_next;
        out_reg   <= out_next;
        final_reg <= final_next;
        ovf_reg   <= ovf_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_out_id    = out_reg.id;
    assign m_out_age   = out_reg.age;
    assign m_out_score = out_reg.key;
    assign m_load_pos  = out_reg.pos;
    assign m_final_res = final_reg;
    assign m_overflow  = ovf_reg;

    // fill count never passes capacity
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_count_reg <= CNT_W'(MAX_RECORDS))
        else $error("fill count beyond capacity");

    // a compare step only touches stored entries
    a_cmp_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.cmp_step |-> (j_reg < fill_count_reg))
        else $error("compare index outside the set");

    // a result is only loaded into an empty result register
    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.emit |-> !m_valid_reg)
        else $error("result register overwritten");

    // after the final result the set is cleared before loading resumes
    a_set_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl.emit && stat.last_row) |=> ##1 (fill_count_reg == '0) && s_ready)
        else $error("set not cleared after final result");

endmodule
`default_nettype wire

>>> rtl/rxs_seq.sv
// microcode sequencer: step counter, control rom and conditional jumps
`default_nettype none
module rxs_seq
    import rxs_pkg::*;
(
    input  wire        aclk,
    input  wire        aresetn,
    input  wire stat_t stat,
    output ctrl_t      ctrl
);

    step_t pc_reg;
    step_t pc_next;
    logic  taken;

    // control rom
    function automatic ctrl_t ucode(step_t a);
        ctrl_t w;
        w        = '0;
        w.cond   = C_ALWAYS;
        w.rd_sel = RD_I;
        case (a)
            ST_LOAD: begin
                w.in_rdy = 1'b1;
                w.cond   = C_LAST_ACC;
                w.t_addr = ST_ROW;
                w.f_addr = ST_LOAD;
            end
            ST_ROW: begin
                w.rd_sel = RD_I;
                w.j_init = 1'b1;
                w.t_addr = ST_LDCUR;
                w.f_addr = ST_LDCUR;
            end
            ST_LDCUR: begin
                w.rd_sel = RD_J;
                w.ld_cur = 1'b1;
                w.cond   = C_J_END;
                w.t_addr = ST_WAIT;
                w.f_addr = ST_CMP;
            end
            ST_CMP: begin
                w.rd_sel   = RD_J1;
                w.cmp_step = 1'b1;
                w.cond     = C_J1_END;
                w.t_addr   = ST_WAIT;
                w.f_addr   = ST_CMP;
            end
            ST_WAIT: begin
                w.cond   = C_OUT_FREE;
                w.t_addr = ST_EMIT;
                w.f_addr = ST_WAIT;
            end
            ST_EMIT: begin
                w.emit   = 1'b1;
                w.cond   = C_LAST_ROW;
                w.t_addr = ST_DONE;
                w.f_addr = ST_ROW;
            end
            ST_DONE: begin
                w.clr_set = 1'b1;
                w.t_addr  = ST_LOAD;
                w.f_addr  = ST_LOAD;
            end
            default: begin
                w.t_addr = ST_LOAD;
                w.f_addr = ST_LOAD;
            end
        endcase
        return w;
    endfunction

    assign ctrl = ucode(pc_reg);

    // condition select
    always_comb begin
        case (ctrl.cond)
            C_ALWAYS:   taken = 1'b1;
            C_LAST_ACC: taken = stat.last_acc;
            C_J_END:    taken = stat.j_end;
            C_J1_END:   taken = stat.j1_end;
            C_OUT_FREE: taken = stat.out_free;
            C_LAST_ROW: taken = stat.last_row;
            default:    taken = 1'b1;
        endcase
    end

    assign pc_next = taken ? ctrl.t_addr : ctrl.f_addr;

    // step counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= ST_LOAD;
        end else begin
            pc_reg <= pc_next;
        end
    end

endmodule
`default_nettype wire
